// ===== rtl/hid_keyboard_report_builder_macros.svh =====
// Assertion macros for the HID keyboard report builder checker.
// Needs a clock and a reset in the scope of each use.
`ifndef HID_KEYBOARD_REPORT_BUILDER_MACROS_SVH
`define HID_KEYBOARD_REPORT_BUILDER_MACROS_SVH

// Same-cycle implication, off during reset.
`define HKRB_ASSERT_IMPL(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("hkrb assertion failed");

// Next-cycle implication, off during reset.
`define HKRB_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("hkrb assertion failed");

// Next-cycle implication that is checked during reset too.
`define HKRB_ASSERT_ALWAYS_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error("hkrb assertion failed");

`endif

// ===== rtl/hkrb_pkg.sv =====
// Shared types and constants of the HID keyboard report builder.
// No dependencies.
package hkrb_pkg;

   localparam logic [2:0] OP_PRESS       = 3'd0;
   localparam logic [2:0] OP_RELEASE     = 3'd1;
   localparam logic [2:0] OP_RELEASE_ALL = 3'd2;
   localparam logic [2:0] OP_SET_MOD     = 3'd3;
   localparam logic [2:0] OP_CLEAR_MOD   = 3'd4;
   localparam logic [2:0] OP_MEDIA       = 3'd5;

   localparam logic [7:0] ID_KEYBOARD = 8'h01;
   localparam logic [7:0] ID_MEDIA    = 8'h02;

   typedef enum logic [2:0] {
      KIND_PRESS,
      KIND_RELEASE,
      KIND_CLEAR_ALL,
      KIND_SET_MOD,
      KIND_CLEAR_MOD,
      KIND_MEDIA,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  key_code;
      logic [7:0]  modifier_mask;
      logic [15:0] media_usage;
   } event_type;

endpackage

// ===== rtl/hid_keyboard_report_builder.sv =====
// HID boot keyboard report builder, top level. An accepted event is registered
// in the front queue and popped by the back end while it is idle; the byte
// sequencer then registers its report beats, one beat per cycle unless stalled,
// and takes no new event before the last beat; two events queue ahead.
// Reset (synchronous, active high) clears the key table, modifier and queue.
// Uses hkrb_pkg, hkrb_front and hkrb_back.
module hid_keyboard_report_builder #(
   parameter int KEY_SLOTS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_key_code,
   input  logic [7:0]  req_modifier_mask,
   input  logic [15:0] req_media_usage,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_report_byte,
   output logic        rsp_report_end,
   output logic        rsp_last
);
   import hkrb_pkg::*;

   logic      evt_valid;
   event_type evt;
   logic      evt_pop;

   hkrb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_key_code      (req_key_code),
      .req_modifier_mask (req_modifier_mask),
      .req_media_usage   (req_media_usage),
      .evt_valid         (evt_valid),
      .evt               (evt),
      .evt_pop           (evt_pop)
   );

   hkrb_back #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .evt_valid       (evt_valid),
      .evt             (evt),
      .evt_pop         (evt_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_report_byte (rsp_report_byte),
      .rsp_report_end  (rsp_report_end),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== rtl/hkrb_front.sv =====
// Front end: accepts key event beats, classifies them, and holds them in
// a two-entry queue for the back end. Uses hkrb_pkg.
module hkrb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_operation,
   input  logic [7:0]          req_key_code,
   input  logic [7:0]          req_modifier_mask,
   input  logic [15:0]         req_media_usage,
   output logic                evt_valid,
   output hkrb_pkg::event_type evt,
   input  logic                evt_pop
);
   import hkrb_pkg::*;

   event_type  queue_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   event_type  evt_in;
   logic       push;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign evt_valid = (count_ff != 2'd0);
   assign evt       = queue_ff[rd_ptr_ff];

   always_comb begin
      evt_in.key_code      = req_key_code;
      evt_in.modifier_mask = req_modifier_mask;
      evt_in.media_usage   = req_media_usage;
      unique case (req_operation)
         OP_PRESS:       evt_in.kind = (req_key_code != 8'h00) ? KIND_PRESS : KIND_NOP;
         OP_RELEASE:     evt_in.kind = (req_key_code != 8'h00) ? KIND_RELEASE : KIND_NOP;
         OP_RELEASE_ALL: evt_in.kind = KIND_CLEAR_ALL;
         OP_SET_MOD:     evt_in.kind = KIND_SET_MOD;
         OP_CLEAR_MOD:   evt_in.kind = KIND_CLEAR_MOD;
         OP_MEDIA:       evt_in.kind = (req_media_usage != 16'h0000) ? KIND_MEDIA : KIND_NOP;
         default:        evt_in.kind = KIND_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= evt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (evt_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         unique case ({push, evt_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== rtl/hkrb_back.sv =====
// Back end: applies one event to the key table and modifier byte, then streams
// reports due (keyboard, media), one beat per cycle unless stalled. Uses hkrb_pkg.
module hkrb_back #(
   parameter int KEY_SLOTS = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                evt_valid,
   input  hkrb_pkg::event_type evt,
   output logic                evt_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_report_byte,
   output logic                rsp_report_end,
   output logic                rsp_last
);
   import hkrb_pkg::*;

   localparam int IdxW       = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int CntW       = $clog2(KEY_SLOTS + 7);
   localparam int KbLast     = KEY_SLOTS + 2;
   localparam int MediaFirst = KEY_SLOTS + 3;
   localparam int MediaLast  = KEY_SLOTS + 5;

   typedef enum logic {S_IDLE, S_EMIT} state_type;
   typedef logic [KEY_SLOTS-1:0][7:0] slots_type;

   state_type                   state_ff;
   slots_type                   slots_ff;
   slots_type                   slots_in;
   logic [7:0]                  mod_ff;
   logic [7:0]                  mod_in;
   logic [15:0]                 media_ff;
   logic                        media_on_ff;
   logic [CntW-1:0]             cnt_ff;
   logic [7:0]                  byte_ff;
   logic                        end_ff;
   logic                        last_ff;
   logic                        valid_ff;
   logic [8*(KEY_SLOTS+1)-1:0]  ext;
   logic                        hit;
   logic [IdxW-1:0]             hit_idx;
   logic                        free;
   logic [IdxW-1:0]             free_idx;
   logic                        changed;
   logic                        out_free;
   logic                        at_kb_last;
   logic                        at_media_last;
   logic                        final_beat;
   logic [IdxW-1:0]             slot_sel;
   logic [7:0]                  byte_sel;

   assign ext = {8'h00, slots_ff};

   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      free     = 1'b0;
      free_idx = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (!hit && slots_ff[i] == evt.key_code) begin
            hit     = 1'b1;
            hit_idx = IdxW'(i);
         end
         if (!free && slots_ff[i] == 8'h00) begin
            free     = 1'b1;
            free_idx = IdxW'(i);
         end
      end
   end

   always_comb begin
      slots_in = slots_ff;
      mod_in   = mod_ff;
      unique case (evt.kind)
         KIND_PRESS: begin
            if (!hit && free) begin
               slots_in[free_idx] = evt.key_code;
            end
         end
         KIND_RELEASE: begin
            if (hit) begin
               for (int j = 0; j < KEY_SLOTS; j++) begin
                  if (IdxW'(j) >= hit_idx) begin
                     slots_in[j] = ext[(j+1)*8 +: 8];
                  end
               end
            end
         end
         KIND_CLEAR_ALL: begin
            slots_in = '0;
            mod_in   = 8'h00;
         end
         KIND_SET_MOD:   mod_in = mod_ff | evt.modifier_mask;
         KIND_CLEAR_MOD: mod_in = mod_ff & ~evt.modifier_mask;
         default: begin
         end
      endcase
   end

   assign changed       = (slots_in != slots_ff) || (mod_in != mod_ff);
   assign evt_pop       = (state_ff == S_IDLE) && evt_valid;
   assign out_free      = !valid_ff || !rsp_stall;
   assign at_kb_last    = (cnt_ff == CntW'(KbLast));
   assign at_media_last = (cnt_ff == CntW'(MediaLast));
   assign final_beat    = (at_kb_last && !media_on_ff) || at_media_last;
   assign slot_sel      = IdxW'(cnt_ff - CntW'(3));

   always_comb begin
      priority if (cnt_ff == CntW'(0)) begin
         byte_sel = ID_KEYBOARD;
      end else if (cnt_ff == CntW'(1)) begin
         byte_sel = mod_ff;
      end else if (cnt_ff == CntW'(2)) begin
         byte_sel = 8'h00;
      end else if (cnt_ff <= CntW'(KbLast)) begin
         byte_sel = slots_ff[slot_sel];
      end else if (cnt_ff == CntW'(MediaFirst)) begin
         byte_sel = ID_MEDIA;
      end else if (cnt_ff == CntW'(MediaFirst + 1)) begin
         byte_sel = media_ff[7:0];
      end else begin
         byte_sel = media_ff[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         slots_ff    <= '0;
         mod_ff      <= 8'h00;
         valid_ff    <= 1'b0;
         media_on_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (valid_ff && !rsp_stall) begin
                  valid_ff <= 1'b0;
               end
               if (evt_valid) begin
                  slots_ff    <= slots_in;
                  mod_ff      <= mod_in;
                  media_ff    <= evt.media_usage;
                  media_on_ff <= (evt.kind == KIND_MEDIA);
                  cnt_ff      <= changed ? CntW'(0) : CntW'(MediaFirst);
                  if (changed || evt.kind == KIND_MEDIA) begin
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  valid_ff <= 1'b1;
                  byte_ff  <= byte_sel;
                  end_ff   <= at_kb_last || at_media_last;
                  last_ff  <= final_beat;
                  cnt_ff   <= cnt_ff + CntW'(1);
                  if (final_beat) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_report_byte = byte_ff;
   assign rsp_report_end  = end_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== rtl/hkrb_checker.sv =====
// Port-level checker for the HID keyboard report builder, with its bind.
// Uses hid_keyboard_report_builder_macros.svh.
`include "hid_keyboard_report_builder_macros.svh"

module hkrb_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_report_byte,
   input logic       rsp_report_end,
   input logic       rsp_last
);
   `HKRB_ASSERT_ALWAYS_NEXT(a_reset_quiet, reset, !rsp_valid)
   `HKRB_ASSERT_IMPL(a_last_ends_report, rsp_valid && rsp_last, rsp_report_end)
   `HKRB_ASSERT_NEXT(a_burst_unbroken, rsp_valid && !rsp_stall && !rsp_last, rsp_valid)
   `HKRB_ASSERT_NEXT(a_stall_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_report_byte) && $stable(rsp_last))
endmodule

bind hid_keyboard_report_builder hkrb_checker u_hkrb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_report_byte (rsp_report_byte),
   .rsp_report_end  (rsp_report_end),
   .rsp_last        (rsp_last)
);

// ===== tb/sv/hid_keyboard_report_builder_tb.sv =====
// Self-checking testbench for hid_keyboard_report_builder: key events in, report beats out,
// every beat compared against a behavioral predictor of the key table and report streams.
// Depends on hkrb_pkg and the hid_keyboard_report_builder RTL.
module hid_keyboard_report_builder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hkrb_pkg::*;

   localparam int KEY_SLOTS     = 6;
   localparam int IDLE_PERCENT  = 23;
   localparam int QUIET_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int MAX_REPORTED  = 10;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [7:0] value;
      logic       report_end;
      logic       event_end;
   } report_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_operation = OP_PRESS;
   logic [7:0]  req_key_code = 8'h00;
   logic [7:0]  req_modifier_mask = 8'h00;
   logic [15:0] req_media_usage = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_report_byte;
   logic        rsp_report_end;
   logic        rsp_last;

   // predictor state
   logic [KEY_SLOTS-1:0][7:0] held_keys     = '0;
   logic [KEY_SLOTS-1:0][7:0] reported_keys = '0;
   logic [7:0]                held_mods     = 8'h00;
   logic [7:0]                reported_mods = 8'h00;
   logic [15:0]               media_pending = 16'h0000;

   report_beat_type expected_beats[$];
   report_beat_type next_beat;
   int              mismatch_count = 0;
   int              quiet_cycles   = 0;
   bit              no_idle        = 1'b0;

   hid_keyboard_report_builder #(
      .KEY_SLOTS(KEY_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_key_code(req_key_code),
      .req_modifier_mask(req_modifier_mask),
      .req_media_usage(req_media_usage),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_report_byte(rsp_report_byte),
      .rsp_report_end(rsp_report_end),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic report_beat_type make_beat(input logic [7:0] value, input logic rend,
                                                 input logic eend);
      report_beat_type b;
      b.value      = value;
      b.report_end = rend;
      b.event_end  = eend;
      return b;
   endfunction

   // Applies one event to the key table and queues the report beats it produces.
   function automatic void predict_reports(input logic [2:0] op, input logic [7:0] code,
                                           input logic [7:0] mask, input logic [15:0] usage);
      logic [KEY_SLOTS-1:0][7:0] compacted;
      int  i;
      int  fill;
      bit  found;
      bit  keyboard_due;
      bit  media_due;
      compacted = '0;
      fill      = 0;
      found     = 1'b0;
      case (op)
         OP_PRESS: begin
            if (code != 8'h00) begin
               for (i = 0; i < KEY_SLOTS; i++)
                  if (held_keys[i] == code) found = 1'b1;
               for (i = 0; i < KEY_SLOTS; i++)
                  if (!found && held_keys[i] == 8'h00) begin
                     held_keys[i] = code;
                     found = 1'b1;
                  end
            end
         end
         OP_RELEASE: begin
            if (code != 8'h00) begin
               for (i = 0; i < KEY_SLOTS; i++)
                  if (!found && held_keys[i] == code) begin
                     held_keys[i] = 8'h00;
                     found = 1'b1;
                  end
               if (found) begin
                  for (i = 0; i < KEY_SLOTS; i++)
                     if (held_keys[i] != 8'h00) begin
                        compacted[fill] = held_keys[i];
                        fill++;
                     end
                  held_keys = compacted;
               end
            end
         end
         OP_RELEASE_ALL: begin
            held_keys = '0;
            held_mods = 8'h00;
         end
         OP_SET_MOD:   held_mods = held_mods | mask;
         OP_CLEAR_MOD: held_mods = held_mods & ~mask;
         OP_MEDIA:     media_pending = usage;
         default: ;
      endcase

      keyboard_due = (held_mods != reported_mods) || (held_keys != reported_keys);
      media_due    = (media_pending != 16'h0000);
      if (keyboard_due) begin
         expected_beats.push_back(make_beat(ID_KEYBOARD, 1'b0, 1'b0));
         expected_beats.push_back(make_beat(held_mods, 1'b0, 1'b0));
         expected_beats.push_back(make_beat(8'h00, 1'b0, 1'b0));
         for (i = 0; i < KEY_SLOTS; i++)
            expected_beats.push_back(make_beat(held_keys[i], i == KEY_SLOTS - 1,
                                               (i == KEY_SLOTS - 1) && !media_due));
         reported_keys = held_keys;
         reported_mods = held_mods;
      end
      if (media_due) begin
         expected_beats.push_back(make_beat(ID_MEDIA, 1'b0, 1'b0));
         expected_beats.push_back(make_beat(media_pending[7:0], 1'b0, 1'b0));
         expected_beats.push_back(make_beat(media_pending[15:8], 1'b1, 1'b1));
         media_pending = 16'h0000;
      end
   endfunction

   task automatic send_event(input logic [2:0] op, input logic [7:0] code,
                             input logic [7:0] mask, input logic [15:0] usage);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_key_code      <= code;
      req_modifier_mask <= mask;
      req_media_usage   <= usage;
      do @(posedge clock); while (req_stall);
      predict_reports(op, code, mask, usage);
   endtask

   // Mostly plausible typing: a small code pool so the table fills, releases of held keys.
   task automatic send_typing_event();
      logic [7:0] code;
      int         held;
      int         pick;
      int         roll;
      int         i;
      code = 8'($urandom);
      held = 0;
      roll = $urandom_range(0, 99);
      for (i = 0; i < KEY_SLOTS; i++)
         if (held_keys[i] != 8'h00) held++;
      if (roll < 45) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)      code = 8'($urandom_range(4, 13));
         else if (pick < 95) code = 8'($urandom_range(1, 255));
         else                code = 8'h00;
         send_event(OP_PRESS, code, 8'($urandom), 16'($urandom));
      end else if (roll < 75) begin
         if (held > 0 && $urandom_range(0, 99) < 85)
            code = held_keys[$urandom_range(0, held - 1)];
         send_event(OP_RELEASE, code, 8'($urandom), 16'($urandom));
      end else if (roll < 82) begin
         send_event(OP_SET_MOD, code, 8'($urandom), 16'($urandom));
      end else if (roll < 89) begin
         send_event(OP_CLEAR_MOD, code, 8'($urandom), 16'($urandom));
      end else if (roll < 94) begin
         send_event(OP_MEDIA, code, 8'($urandom),
                    ($urandom_range(0, 99) < 80) ? 16'($urandom_range(1, 65535)) : 16'h0000);
      end else if (roll < 97) begin
         send_event(OP_RELEASE_ALL, code, 8'($urandom), 16'($urandom));
      end else begin
         send_event($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI, code, 8'($urandom),
                    16'($urandom));
      end
   endtask

   task automatic test_directed();
      send_event(OP_PRESS, 8'h00, 8'($urandom), 16'($urandom));
      send_event(OP_PRESS, 8'h04, 8'($urandom), 16'($urandom));
      send_event(OP_PRESS, 8'h04, 8'($urandom), 16'($urandom));
      send_event(OP_PRESS, 8'hFF, 8'($urandom), 16'($urandom));
      send_event(OP_PRESS, 8'h05, 8'($urandom), 16'($urandom));
      send_event(OP_PRESS, 8'h06, 8'($urandom), 16'($urandom));
      send_event(OP_PRESS, 8'h07, 8'($urandom), 16'($urandom));
      send_event(OP_PRESS, 8'h80, 8'($urandom), 16'($urandom));
      send_event(OP_PRESS, 8'h09, 8'($urandom), 16'($urandom));
      send_event(OP_RELEASE, 8'h00, 8'($urandom), 16'($urandom));
      send_event(OP_RELEASE, 8'h2A, 8'($urandom), 16'($urandom));
      send_event(OP_RELEASE, 8'hFF, 8'($urandom), 16'($urandom));
      send_event(OP_SET_MOD, 8'($urandom), 8'hFF, 16'($urandom));
      send_event(OP_CLEAR_MOD, 8'($urandom), 8'h55, 16'($urandom));
      send_event(OP_SET_MOD, 8'($urandom), 8'h00, 16'($urandom));
      send_event(OP_MEDIA, 8'($urandom), 8'($urandom), 16'hFFFF);
      send_event(OP_MEDIA, 8'($urandom), 8'($urandom), 16'h0000);
      send_event(OP_MEDIA, 8'($urandom), 8'($urandom), 16'h00E9);
      send_event(OP_RELEASE, 8'h04, 8'($urandom), 16'($urandom));
      send_event(OP_SPARE_LO, 8'h05, 8'hFF, 16'hFFFF);
      send_event(OP_SPARE_HI, 8'h06, 8'hFF, 16'hFFFF);
      send_event(OP_RELEASE_ALL, 8'($urandom), 8'($urandom), 16'($urandom));
      send_event(OP_RELEASE_ALL, 8'($urandom), 8'($urandom), 16'($urandom));
      send_event(OP_CLEAR_MOD, 8'($urandom), 8'hFF, 16'($urandom));
   endtask

   task automatic test_random_typing();
      repeat (220) send_typing_event();
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (100) send_typing_event();
      no_idle = 1'b0;
   endtask

   task automatic test_random_noise();
      repeat (85)
         send_event(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   always @(posedge clock) begin
      rsp_stall <= !reset && !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
               $display("unexpected report beat: byte %h end %b last %b",
                        rsp_report_byte, rsp_report_end, rsp_last);
         end else begin
            next_beat = expected_beats.pop_front();
            if (rsp_report_byte !== next_beat.value || rsp_report_end !== next_beat.report_end
                || rsp_last !== next_beat.event_end) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTED)
                  $display("beat mismatch: expected byte %h end %b last %b, got %h %b %b",
                           next_beat.value, next_beat.report_end, next_beat.event_end,
                           rsp_report_byte, rsp_report_end, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_typing();
      test_back_to_back();
      test_random_noise();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hkrb_pkg.sv
rtl/hkrb_front.sv
rtl/hkrb_back.sv
rtl/hid_keyboard_report_builder.sv
rtl/hkrb_checker.sv
tb/sv/hid_keyboard_report_builder_tb.sv
